// ===== rtl/hid_boot_keyboard_report_differ_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the boot keyboard report differ
// Shared forms for the concurrent checks of the RTL.
// ----------------------------------------------------------------------------
`ifndef HID_BOOT_KEYBOARD_REPORT_DIFFER_CORE_ASSERT_SVH
`define HID_BOOT_KEYBOARD_REPORT_DIFFER_CORE_ASSERT_SVH

// property holds at every edge outside reset
`define HBKRD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// condition at one edge implies consequence at the next
`define HBKRD_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== rtl/hbkrd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbkrd_pkg
// Types and constants of the boot keyboard report differ.
// ----------------------------------------------------------------------------
package hbkrd_pkg;

   localparam int N_KEYS = 6;
   localparam int N_MODS = 8;

   localparam logic [7:0] MOD_BASE = 8'hE0;
   localparam logic [7:0] MIN_KEY  = 8'd4;
   localparam logic [7:0] MIN_LEN  = 8'd8;

   // event slots in emission order
   localparam int MOD_REL_LO = 0;
   localparam int KEY_REL_LO = MOD_REL_LO + N_MODS;
   localparam int MOD_PRS_LO = KEY_REL_LO + N_KEYS;
   localparam int KEY_PRS_LO = MOD_PRS_LO + N_MODS;
   localparam int EV_SLOTS   = KEY_PRS_LO + N_KEYS;
   localparam int COUNT_W    = $clog2(EV_SLOTS + 1);

   localparam int DEFAULT_MAX_EVENTS = 20;

   typedef enum logic [1:0] {
      STATUS_EVENT     = 2'd0,
      STATUS_NO_CHANGE = 2'd1,
      STATUS_MALFORMED = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   typedef logic [N_KEYS-1:0][7:0] keys_type;

endpackage

// ===== rtl/hid_boot_keyboard_report_differ_core.sv =====
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_differ_core
// Compares boot keyboard reports with the held state and streams key events.
//
//   channel  dir  transfer                           beats per report
//   req_     in   one 8-byte report plus length/time 1
//   rsp_     out  one event or status result         1 to 20
//
// A report moves input register -> evaluation -> event queue -> result
// register. The event queue sends one result per cycle while the result
// register is free or rsp_tready is high; a no-change, malformed or
// overflow report gives a single status result. The next report is
// evaluated in the cycle its predecessor's last result leaves the queue.
// Reset clears the held keys and modifiers.
// rsp_tready low holds the result register and backs up to req_tready.
// ----------------------------------------------------------------------------
`include "hid_boot_keyboard_report_differ_core_assert.svh"

module hid_boot_keyboard_report_differ_core
   import hbkrd_pkg::*;
#(
   parameter int MAX_EVENTS = DEFAULT_MAX_EVENTS
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   // modifier_bits, reserved_byte, key_0..key_5, report_length, arrival_time
   input  logic [135:0] req_tdata,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // usage_code, pressed, event_time, zero fill
   output logic [79:0]  rsp_tdata,
   // status
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_mods_ff;
   logic [7:0]            in_resv_ff;
   keys_type              in_keys_ff;
   logic [7:0]            in_len_ff;
   logic [63:0]           in_time_ff;

   // held state
   keys_type              held_keys_ff, held_keys_in;
   logic [7:0]            held_mods_ff, held_mods_in;

   // event queue
   logic [EV_SLOTS-1:0]   em_mask_ff, em_mask_in;
   logic                  em_stat_ff, em_stat_in;
   status_type            em_code_ff, em_code_in;
   keys_type              em_rel_keys_ff;
   keys_type              em_prs_keys_ff;
   logic [63:0]           em_time_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_usage_ff;
   logic                  rsp_pressed_ff;
   logic [63:0]           rsp_time_ff;
   status_type            rsp_status_ff;
   logic                  rsp_last_ff;

   // evaluation
   logic                  bad;
   logic                  over;
   logic [EV_SLOTS-1:0]   ev_mask;
   logic [COUNT_W-1:0]    ev_count;
   logic [N_KEYS-1:0]     rel_found;
   logic [N_KEYS-1:0]     prs_found;

   // selection
   logic [EV_SLOTS-1:0]   sel_one;
   logic [7:0]            sel_usage;
   logic                  sel_pressed;
   logic                  sel_last;
   logic                  em_valid;
   logic                  out_load_ok;
   logic                  em_adv;
   logic                  em_free;
   logic                  eval_fire;
   logic                  req_fire;

   assign em_valid    = em_stat_ff || (|em_mask_ff);
   assign out_load_ok = !rsp_valid_ff || rsp_tready;
   assign em_adv      = em_valid && out_load_ok;
   assign em_free     = !em_valid || (out_load_ok && sel_last);
   assign eval_fire   = in_valid_ff && em_free;
   assign req_tready  = !in_valid_ff || eval_fire;
   assign req_fire    = req_tvalid && req_tready;

   always_comb begin
      bad = (in_len_ff < MIN_LEN) || (in_resv_ff != 8'd0);
      for (int i = 0; i < N_KEYS; i++) begin
         if (in_keys_ff[i] != 8'd0 && in_keys_ff[i] < MIN_KEY) begin
            bad = 1'b1;
         end
         for (int j = i + 1; j < N_KEYS; j++) begin
            if (in_keys_ff[i] != 8'd0 && in_keys_ff[i] == in_keys_ff[j]) begin
               bad = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rel_found = '0;
      prs_found = '0;
      for (int i = 0; i < N_KEYS; i++) begin
         for (int j = 0; j < N_KEYS; j++) begin
            if (held_keys_ff[i] == in_keys_ff[j]) begin
               rel_found[i] = 1'b1;
            end
            if (in_keys_ff[i] == held_keys_ff[j]) begin
               prs_found[i] = 1'b1;
            end
         end
      end
      ev_mask = '0;
      ev_mask[MOD_REL_LO +: N_MODS] = held_mods_ff & ~in_mods_ff;
      ev_mask[MOD_PRS_LO +: N_MODS] = in_mods_ff & ~held_mods_ff;
      for (int i = 0; i < N_KEYS; i++) begin
         ev_mask[KEY_REL_LO + i] = (held_keys_ff[i] != 8'd0) && !rel_found[i];
         ev_mask[KEY_PRS_LO + i] = (in_keys_ff[i] != 8'd0) && !prs_found[i];
      end
      ev_count = '0;
      for (int k = 0; k < EV_SLOTS; k++) begin
         ev_count = ev_count + COUNT_W'(ev_mask[k]);
      end
      over = ev_count > COUNT_W'(MAX_EVENTS);
   end

   // lowest pending slot is the next event
   always_comb begin
      sel_one     = em_mask_ff & (~em_mask_ff + EV_SLOTS'(1));
      sel_last    = (em_mask_ff & ~sel_one) == '0;
      sel_pressed = |sel_one[EV_SLOTS-1:MOD_PRS_LO];
      sel_usage   = 8'd0;
      for (int b = 0; b < N_MODS; b++) begin
         if (sel_one[MOD_REL_LO + b] || sel_one[MOD_PRS_LO + b]) begin
            sel_usage = sel_usage | (MOD_BASE + 8'(b));
         end
      end
      for (int i = 0; i < N_KEYS; i++) begin
         if (sel_one[KEY_REL_LO + i]) begin
            sel_usage = sel_usage | em_rel_keys_ff[i];
         end
         if (sel_one[KEY_PRS_LO + i]) begin
            sel_usage = sel_usage | em_prs_keys_ff[i];
         end
      end
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      held_keys_in = held_keys_ff;
      held_mods_in = held_mods_ff;
      em_mask_in   = em_mask_ff;
      em_stat_in   = em_stat_ff;
      em_code_in   = em_code_ff;
      rsp_valid_in = rsp_valid_ff;

      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (eval_fire) begin
         in_valid_in = 1'b0;
      end

      if (em_adv) begin
         em_mask_in = em_mask_ff & ~sel_one;
         em_stat_in = 1'b0;
      end
      if (eval_fire) begin
         em_mask_in = '0;
         em_stat_in = 1'b1;
         if (bad) begin
            em_code_in = STATUS_MALFORMED;
         end else if (over) begin
            em_code_in = STATUS_OVERFLOW;
         end else begin
            held_keys_in = in_keys_ff;
            held_mods_in = in_mods_ff;
            if (ev_mask == '0) begin
               em_code_in = STATUS_NO_CHANGE;
            end else begin
               em_mask_in = ev_mask;
               em_stat_in = 1'b0;
               em_code_in = STATUS_EVENT;
            end
         end
      end

      if (em_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         held_keys_ff <= '0;
         held_mods_ff <= '0;
         em_mask_ff   <= '0;
         em_stat_ff   <= 1'b0;
         em_code_ff   <= STATUS_EVENT;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         held_keys_ff <= held_keys_in;
         held_mods_ff <= held_mods_in;
         em_mask_ff   <= em_mask_in;
         em_stat_ff   <= em_stat_in;
         em_code_ff   <= em_code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mods_ff <= req_tdata[7:0];
         in_resv_ff <= req_tdata[15:8];
         in_keys_ff <= req_tdata[63:16];
         in_len_ff  <= req_tdata[71:64];
         in_time_ff <= req_tdata[135:72];
      end
      if (eval_fire) begin
         em_rel_keys_ff <= held_keys_ff;
         em_prs_keys_ff <= in_keys_ff;
         em_time_ff     <= in_time_ff;
      end
      if (em_adv) begin
         rsp_time_ff <= em_time_ff;
         rsp_last_ff <= sel_last;
         if (em_stat_ff) begin
            rsp_usage_ff   <= 8'd0;
            rsp_pressed_ff <= 1'b0;
            rsp_status_ff  <= em_code_ff;
         end else begin
            rsp_usage_ff   <= sel_usage;
            rsp_pressed_ff <= sel_pressed;
            rsp_status_ff  <= STATUS_EVENT;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_time_ff, rsp_pressed_ff, rsp_usage_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `HBKRD_ASSERT(a_status_is_last, clock, reset,
      (rsp_valid_ff && rsp_status_ff != STATUS_EVENT) |-> rsp_last_ff,
      "status result without tlast")
   `HBKRD_ASSERT(a_queue_bound, clock, reset,
      $countones(em_mask_ff) <= MAX_EVENTS,
      "event queue holds more than the event limit")
   `HBKRD_ASSERT(a_queue_exclusive, clock, reset,
      !(em_stat_ff && (|em_mask_ff)),
      "status result queued together with events")
   `HBKRD_ASSERT_NEXT(a_reject_keeps_state, clock, reset,
      eval_fire && (bad || over),
      $stable(held_keys_ff) && $stable(held_mods_ff),
      "rejected report changed the held state")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: boot keyboard report differ
// Streams directed and random boot keyboard reports into the core with random
// gaps and back-pressure on both sides. Each result transfer is checked field
// by field against a local predictor of held keys and modifiers or a typed row.
// ----------------------------------------------------------------------------
module tb;
   import hbkrd_pkg::*;

   localparam int EVENT_LIMIT  = DEFAULT_MAX_EVENTS;
   localparam int RANDOM_ITEMS = 160;
   localparam int MAX_GAP      = 18;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 40;

   // first member in the top bits: matches req_tdata layout
   typedef struct packed {
      logic [63:0] stamp;
      logic [7:0]  len;
      keys_type    keys;
      logic [7:0]  resv;
      logic [7:0]  mods;
   } report_type;

   typedef struct {
      logic [7:0]  usage_code;
      logic        pressed;
      logic [63:0] event_time;
      status_type  status;
      logic        last_event;
   } key_event_type;

   typedef struct {
      report_type  rpt;
      bit          typed;
      logic [7:0]  usage;
      logic        pressed;
      status_type  status;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   // typed expectation travels with the report
   bit           row_typed = 1'b0;
   logic [7:0]   row_usage = '0;
   logic         row_pressed = 1'b0;
   status_type   row_status = STATUS_EVENT;

   keys_type     held_keys_m = '0;
   logic [7:0]   held_mods_m = '0;
   key_event_type    step_events[$];
   key_event_type    pending_events[$];
   directed_row_type directed_rows[$];

   keys_type     prev_keys = '0;
   logic [7:0]   prev_mods = '0;
   bit           no_idle = 1'b0;
   int           rsp_stall = 0;
   int           idle_cycles = 0;
   int           mismatches = 0;

   hid_boot_keyboard_report_differ_core #(
      .MAX_EVENTS(EVENT_LIMIT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic bit key_present(input keys_type keys, input logic [7:0] k);
      for (int i = 0; i < N_KEYS; i++)
         if (keys[i] == k) return 1'b1;
      return 1'b0;
   endfunction

   // fills step_events with the results of one report, updates held state if accepted
   function automatic void predict_key_events(input report_type r);
      bit            bad;
      logic [7:0]    usages[$];
      logic          downs[$];
      key_event_type ev;
      step_events.delete();
      bad = (r.len < MIN_LEN) || (r.resv != 8'h00);
      for (int i = 0; i < N_KEYS; i++)
         if (r.keys[i] != 8'h00) begin
            if (r.keys[i] < MIN_KEY) bad = 1'b1;
            for (int j = i + 1; j < N_KEYS; j++)
               if (r.keys[i] == r.keys[j]) bad = 1'b1;
         end
      ev.usage_code = 8'h00;
      ev.pressed    = 1'b0;
      ev.event_time = r.stamp;
      ev.last_event = 1'b1;
      if (bad) begin
         ev.status = STATUS_MALFORMED;
         step_events.push_back(ev);
         return;
      end
      for (int b = 0; b < N_MODS; b++)
         if (held_mods_m[b] && !r.mods[b]) begin
            usages.push_back(MOD_BASE + 8'(b));
            downs.push_back(1'b0);
         end
      for (int i = 0; i < N_KEYS; i++)
         if (held_keys_m[i] != 8'h00 && !key_present(r.keys, held_keys_m[i])) begin
            usages.push_back(held_keys_m[i]);
            downs.push_back(1'b0);
         end
      for (int b = 0; b < N_MODS; b++)
         if (r.mods[b] && !held_mods_m[b]) begin
            usages.push_back(MOD_BASE + 8'(b));
            downs.push_back(1'b1);
         end
      for (int i = 0; i < N_KEYS; i++)
         if (r.keys[i] != 8'h00 && !key_present(held_keys_m, r.keys[i])) begin
            usages.push_back(r.keys[i]);
            downs.push_back(1'b1);
         end
      if (usages.size() > EVENT_LIMIT) begin
         ev.status = STATUS_OVERFLOW;
         step_events.push_back(ev);
         return;
      end
      held_keys_m = r.keys;
      held_mods_m = r.mods;
      if (usages.size() == 0) begin
         ev.status = STATUS_NO_CHANGE;
         step_events.push_back(ev);
         return;
      end
      for (int k = 0; k < usages.size(); k++) begin
         ev.usage_code = usages[k];
         ev.pressed    = downs[k];
         ev.status     = STATUS_EVENT;
         ev.last_event = (k == usages.size() - 1);
         step_events.push_back(ev);
      end
   endfunction

   function automatic report_type mk(input logic [7:0] mods, input logic [7:0] resv,
                                     input logic [7:0] k0, input logic [7:0] k1,
                                     input logic [7:0] k2, input logic [7:0] k3,
                                     input logic [7:0] k4, input logic [7:0] k5,
                                     input logic [7:0] len, input logic [63:0] stamp);
      report_type r;
      r.mods    = mods;
      r.resv    = resv;
      r.keys[0] = k0;
      r.keys[1] = k1;
      r.keys[2] = k2;
      r.keys[3] = k3;
      r.keys[4] = k4;
      r.keys[5] = k5;
      r.len     = len;
      r.stamp   = stamp;
      return r;
   endfunction

   function automatic void add_row(input report_type r, input bit typed,
                                   input logic [7:0] usage,
                                   input logic pressed, input status_type st);
      directed_row_type row;
      row.rpt     = r;
      row.typed   = typed;
      row.usage   = usage;
      row.pressed = pressed;
      row.status  = st;
      directed_rows.push_back(row);
   endfunction

   // mostly well-formed reports that overlap the previous one, the rest mostly flawed
   function automatic report_type gen_report();
      report_type r;
      int         nk, a, b, tries;
      logic [7:0] cand, tmp;
      r.stamp = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 78) begin
         r.len  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8, 255)) : MIN_LEN;
         r.resv = 8'h00;
         case ($urandom_range(0, 2))
            0: r.mods = prev_mods;
            1: r.mods = prev_mods ^ (8'h01 << $urandom_range(0, 7));
            default: r.mods = 8'($urandom);
         endcase
         r.keys = '0;
         nk = $urandom_range(0, N_KEYS);
         for (int i = 0; i < nk; i++) begin
            tries = 0;
            do begin
               a = $urandom_range(0, N_KEYS - 1);
               if ($urandom_range(0, 1) && prev_keys[a] != 8'h00)
                  cand = prev_keys[a];
               else if ($urandom_range(0, 3) == 0)
                  cand = 8'($urandom_range(4, 255));
               else
                  cand = 8'($urandom_range(4, 15));
               tries++;
            end while (key_present(r.keys, cand) && tries < 8);
            if (!key_present(r.keys, cand)) r.keys[i] = cand;
         end
         repeat (3) begin
            a = $urandom_range(0, N_KEYS - 1);
            b = $urandom_range(0, N_KEYS - 1);
            tmp = r.keys[a];
            r.keys[a] = r.keys[b];
            r.keys[b] = tmp;
         end
         prev_mods = r.mods;
         prev_keys = r.keys;
      end else begin
         r.mods = 8'($urandom);
         r.resv = 8'h00;
         r.len  = 8'($urandom_range(8, 255));
         for (int i = 0; i < N_KEYS; i++)
            r.keys[i] = 8'($urandom);
         a = $urandom_range(0, N_KEYS - 1);
         b = (a + 1 + $urandom_range(0, N_KEYS - 2)) % N_KEYS;
         case ($urandom_range(0, 4))
            0: r.len = 8'($urandom_range(0, 7));
            1: r.resv = 8'($urandom_range(1, 255));
            2: r.keys[a] = 8'($urandom_range(1, 3));
            3: begin
               r.keys[a] = 8'($urandom_range(4, 255));
               r.keys[b] = r.keys[a];
            end
            default: begin
               r.resv = 8'($urandom);
               r.len  = 8'($urandom);
            end
         endcase
      end
      return r;
   endfunction

   task automatic send_report(input report_type r, input bit typed, input logic [7:0] usage,
                              input logic pressed, input status_type st);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid  <= 1'b1;
      req_tdata   <= r;
      row_typed   <= typed;
      row_usage   <= usage;
      row_pressed <= pressed;
      row_status  <= st;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result sink with per-transfer stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            rsp_stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
         else if (rsp_stall > 0)
            rsp_stall--;
         rsp_tready <= (rsp_stall == 0);
      end
   end

   always @(posedge clock) begin : monitor
      key_event_type ev;
      key_event_type want;
      report_type    r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r = req_tdata;
            predict_key_events(r);
            if (row_typed) begin
               ev.usage_code = row_usage;
               ev.pressed    = row_pressed;
               ev.event_time = r.stamp;
               ev.status     = row_status;
               ev.last_event = 1'b1;
               pending_events.push_back(ev);
            end else begin
               foreach (step_events[k]) pending_events.push_back(step_events[k]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               $display("%0t unexpected result: expected none, actual usage %h status %0d",
                        $time, rsp_tdata[7:0], rsp_tuser);
               mismatches++;
            end else begin
               want = pending_events.pop_front();
               check_field("usage_code", 64'(want.usage_code), 64'(rsp_tdata[7:0]));
               check_field("pressed",    64'(want.pressed),    64'(rsp_tdata[8]));
               check_field("event_time", want.event_time,      rsp_tdata[72:9]);
               check_field("status",     64'(want.status),     64'(rsp_tuser));
               check_field("last_event", 64'(want.last_event), 64'(rsp_tlast));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      //      mods   resv   k0     k1     k2     k3     k4     k5     len    stamp
      add_row(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 64'd1),
              1, 8'h00, 1'b0, STATUS_NO_CHANGE);
      add_row(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd7, 64'd2),
              1, 8'h00, 1'b0, STATUS_MALFORMED);
      add_row(mk(8'hFF, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 64'd3),
              1, 8'h00, 1'b0, STATUS_MALFORMED);
      add_row(mk(8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 64'd4),
              1, 8'h00, 1'b0, STATUS_MALFORMED);
      add_row(mk(8'h00, 8'h01, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 64'd5),
              1, 8'h00, 1'b0, STATUS_MALFORMED);
      add_row(mk(8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 64'd6),
              1, 8'h00, 1'b0, STATUS_MALFORMED);
      // low usage in the last slot
      add_row(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'd8, 64'd7),
              1, 8'h00, 1'b0, STATUS_MALFORMED);
      add_row(mk(8'h00, 8'h00, 8'h00, 8'h2C, 8'h00, 8'h00, 8'h2C, 8'h00, 8'd8, 64'd8),
              1, 8'h00, 1'b0, STATUS_MALFORMED);
      add_row(mk(8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'd8, 64'd9),
              1, 8'h00, 1'b0, STATUS_MALFORMED);
      add_row(mk(8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 64'd10),
              1, 8'h04, 1'b1, STATUS_EVENT);
      add_row(mk(8'h00, 8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8, '1),
              1, 8'h00, 1'b0, STATUS_NO_CHANGE);
      add_row(mk(8'hFF, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd8, 64'd12),
              0, 8'h00, 1'b0, STATUS_EVENT);
      // full flip: 20 events, the most a report can give
      add_row(mk(8'h00, 8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA, 8'd255, '1),
              0, 8'h00, 1'b0, STATUS_EVENT);
      add_row(mk(8'hFF, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'd8, 64'd0),
              0, 8'h00, 1'b0, STATUS_EVENT);
      add_row(mk(8'hFF, 8'h00, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04, 8'd8, 64'd15),
              1, 8'h00, 1'b0, STATUS_NO_CHANGE);
      add_row(mk(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07, 8'd8, 64'd16),
              0, 8'h00, 1'b0, STATUS_EVENT);
      add_row(mk(8'h80, 8'h00, 8'h05, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'd9, 64'd17),
              0, 8'h00, 1'b0, STATUS_EVENT);
      add_row(mk(8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd255, 64'd18),
              1, 8'h00, 1'b0, STATUS_MALFORMED);
      // malformed report above must have left the state alone
      add_row(mk(8'h80, 8'h00, 8'h00, 8'h07, 8'h00, 8'h00, 8'h05, 8'h00, 8'd8, 64'd19),
              1, 8'h00, 1'b0, STATUS_NO_CHANGE);
      add_row(mk(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'd8, 64'd20),
              0, 8'h00, 1'b0, STATUS_EVENT);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_report(directed_rows[i].rpt, directed_rows[i].typed, directed_rows[i].usage,
                     directed_rows[i].pressed, directed_rows[i].status);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 16 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_events.size() != 0) @(posedge clock);
         end
         send_report(gen_report(), 1'b0, 8'h00, 1'b0, STATUS_EVENT);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_events.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_events.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hbkrd_pkg.sv
rtl/hid_boot_keyboard_report_differ_core.sv
tb/sv/tb.sv
